### src/ebpt_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the base-2 euler probable-prime block
// no dependencies

package ebpt_pkg;

  // candidate width and its split into two 64-bit halves
  localparam int CAND_BITS = 128;
  localparam int HALF_BITS = 64;
  localparam int HIGH_USED = CAND_BITS - HALF_BITS;
  localparam logic [HALF_BITS-1:0] HIGH_MASK =
    HALF_BITS'((129'(1) << HIGH_USED) - 129'(1));

  // stream widths
  localparam int IN_DATA_BITS  = 128;
  localparam int OUT_DATA_BITS = 136;

  typedef logic [127:0] wide_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_EXP  = 7'b0000100,
    ST_SQD  = 7'b0001000,
    ST_SQA  = 7'b0010000,
    ST_DBL  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

endpackage

### src/ebpt_modadd.sv
`timescale 1ns / 1ps
// shared modular adder: (x + y) mod m for x, y below m
// depends on ebpt_pkg

module ebpt_modadd (
  input  ebpt_pkg::wide_t x,
  input  ebpt_pkg::wide_t y,
  input  ebpt_pkg::wide_t m,
  output ebpt_pkg::wide_t sum
);

  logic [128:0] raw;
  logic [128:0] red;

  // wide add, then one conditional subtract of the modulus
  always_comb begin
    raw = {1'b0, x} + {1'b0, y};
    red = raw - {1'b0, m};
    if (raw >= {1'b0, m}) begin
      sum = red[127:0];
    end else begin
      sum = raw[127:0];
    end
  end

endmodule

### src/euler_base2_prp_test_core.sv
`timescale 1ns / 1ps
// top level: sequencer driving the shared modular adder, output register
// depends on ebpt_pkg and ebpt_modadd

// One candidate is handled at a time. After the word is taken the block scans
// down from bit 127 for the top set bit, one bit at a time, then for every
// lower bit down to bit 1 performs a modular squaring as 128 shift-and-add
// steps, each a doubling and, for a set multiplier bit, an add on the single
// 128-bit modular adder, plus a doubling when the bit is set. The modular
// adder is shared by every step. The result word sits in an output register,
// so a new candidate can be taken while it waits.

module euler_base2_prp_test_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // cand_low [63:0], cand_high [127:64]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [135:0] m_axis_tdata   // is_probable_prime [0], residue_low [64:1],
                                      // residue_high [128:65], zero pad above
);

  ebpt_pkg::state_t state;
  ebpt_pkg::wide_t  n;
  ebpt_pkg::wide_t  r;
  ebpt_pkg::wide_t  a;
  ebpt_pkg::wide_t  acc;
  logic [7:0]       pos;
  logic [7:0]       pos_m1;
  logic [6:0]       idx;
  logic             zero_cand;

  ebpt_pkg::wide_t  ux;
  ebpt_pkg::wide_t  uy;
  ebpt_pkg::wide_t  usum;
  ebpt_pkg::wide_t  target;
  logic             euler;

  logic             out_valid;
  logic [135:0]     out_data;

  assign pos_m1        = pos - 8'd1;
  assign s_axis_tready = (state == ebpt_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // operand select for the shared adder
  always_comb begin
    ux = acc;
    uy = acc;
    unique case (state)
      ebpt_pkg::ST_SQA: begin
        ux = acc;
        uy = a;
      end
      ebpt_pkg::ST_DBL: begin
        ux = r;
        uy = r;
      end
      default: begin
        ux = acc;
        uy = acc;
      end
    endcase
  end

  ebpt_modadd u_modadd (
    .x   (ux),
    .y   (uy),
    .m   (n),
    .sum (usum)
  );

  // euler criterion target
  assign euler  = n[1] ^ n[2];
  assign target = euler ? (n - 128'd1) : 128'd1;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ebpt_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output word valid: set when the result is loaded, cleared when taken
      if ((state == ebpt_pkg::ST_FIN) && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ebpt_pkg::ST_IDLE: begin
          if (s_axis_tvalid) begin
            n         <= {s_axis_tdata[127:64] & ebpt_pkg::HIGH_MASK, s_axis_tdata[63:0]};
            zero_cand <= ((s_axis_tdata[127:64] & ebpt_pkg::HIGH_MASK) == 64'd0) &&
                         (s_axis_tdata[63:0] == 64'd0);
            r         <= 128'd1;
            pos       <= 8'(ebpt_pkg::CAND_BITS);
            state     <= ebpt_pkg::ST_SCAN;
          end
        end
        ebpt_pkg::ST_SCAN: begin
          if (pos > 8'd1) begin
            pos <= pos_m1;
            if (n[pos_m1[6:0]]) begin
              r     <= 128'd2;
              state <= ebpt_pkg::ST_EXP;
            end
          end else begin
            state <= ebpt_pkg::ST_FIN;
          end
        end
        ebpt_pkg::ST_EXP: begin
          if (pos > 8'd1) begin
            pos   <= pos_m1;
            a     <= r;
            acc   <= 128'd0;
            idx   <= 7'd127;
            state <= ebpt_pkg::ST_SQD;
          end else begin
            state <= ebpt_pkg::ST_FIN;
          end
        end
        ebpt_pkg::ST_SQD: begin
          acc <= usum;
          if (a[idx]) begin
            state <= ebpt_pkg::ST_SQA;
          end else if (idx == 7'd0) begin
            r     <= usum;
            state <= n[pos[6:0]] ? ebpt_pkg::ST_DBL : ebpt_pkg::ST_EXP;
          end else begin
            idx <= idx - 7'd1;
          end
        end
        ebpt_pkg::ST_SQA: begin
          acc <= usum;
          if (idx == 7'd0) begin
            r     <= usum;
            state <= n[pos[6:0]] ? ebpt_pkg::ST_DBL : ebpt_pkg::ST_EXP;
          end else begin
            idx   <= idx - 7'd1;
            state <= ebpt_pkg::ST_SQD;
          end
        end
        ebpt_pkg::ST_DBL: begin
          r     <= usum;
          state <= ebpt_pkg::ST_EXP;
        end
        ebpt_pkg::ST_FIN: begin
          // load the result word once the output register is free
          if (!out_valid || m_axis_tready) begin
            if (zero_cand) begin
              out_data <= 136'd0;
            end else begin
              out_data <= {7'd0, r, (r == target)};
            end
            state <= ebpt_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= ebpt_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_sqa_bit: assert property (@(posedge clk) disable iff (rst)
    (state == ebpt_pkg::ST_SQA) |-> a[idx])
    else $error("add step entered with clear multiplier bit");
  a_acc_red: assert property (@(posedge clk) disable iff (rst)
    (state == ebpt_pkg::ST_SQD) |-> (acc < n))
    else $error("square accumulator not reduced");
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == ebpt_pkg::ST_FIN) && !out_valid |=> out_valid)
    else $error("result not loaded");

endmodule

### dv/euler_base2_prp_test_core_tb.sv
`timescale 1ns / 1ps
// testbench for euler_base2_prp_test_core: directed and random candidates,
// an in-bench square-and-double predictor, random idling on both stream sides
// depends on ebpt_pkg and the euler_base2_prp_test_core rtl

module euler_base2_prp_test_core_tb;

  typedef struct packed {
    logic         prime;
    logic [127:0] resid;
  } verdict_t;

  // (a + b) mod m for a, b < m, with the carry kept
  function automatic logic [127:0] mod_add(logic [127:0] a, logic [127:0] b,
                                           logic [127:0] m);
    logic [128:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[127:0];
  endfunction

  // a*a mod m by shift-and-add from the top bit
  function automatic logic [127:0] mod_square(logic [127:0] a, logic [127:0] m);
    logic [127:0] r;
    r = '0;
    for (int i = 127; i >= 0; i--) begin
      r = mod_add(r, r, m);
      if (a[i]) r = mod_add(r, a, m);
    end
    return r;
  endfunction

  // 2^(n>>1) mod n and the euler criterion
  function automatic verdict_t euler_verdict(logic [127:0] n);
    verdict_t v;
    logic [127:0] r, goal;
    int pos;
    if (n == '0) begin
      v.prime = 1'b0;
      v.resid = '0;
      return v;
    end
    r = 128'd1;
    pos = ebpt_pkg::CAND_BITS;
    while (pos > 1) begin
      pos--;
      if (n[pos]) begin
        r = 128'd2;
        break;
      end
    end
    while (pos > 1) begin
      pos--;
      r = mod_square(r, n);
      if (n[pos]) r = mod_add(r, r, n);
    end
    goal = (n[1] ^ n[2]) ? n - 128'd1 : 128'd1;
    v.prime = (r == goal);
    v.resid = r;
    return v;
  endfunction

  // expected verdicts in order of acceptance
  class verdict_board;
    verdict_t pending[$];
    int errors = 0;

    function void note_cand(logic [127:0] n);
      pending.push_back(euler_verdict(n));
    endfunction

    function void check_word(logic [135:0] w);
      verdict_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w[0] !== e.prime) begin
        $error("is_probable_prime: expected %0d, got %0d", e.prime, w[0]);
        errors++;
      end
      if (w[64:1] !== e.resid[63:0]) begin
        $error("residue_low: expected %h, got %h", e.resid[63:0], w[64:1]);
        errors++;
      end
      if (w[128:65] !== e.resid[127:64]) begin
        $error("residue_high: expected %h, got %h", e.resid[127:64], w[128:65]);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // cand_low [63:0], cand_high [127:64]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;        // is_probable_prime [0], residue_low [64:1],
                                     // residue_high [128:65], zero pad above

  verdict_board board = new();
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  always #4 clk = ~clk;

  euler_base2_prp_test_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // push one candidate word, with a random gap before it unless bursting
  task automatic send_cand(logic [127:0] n);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= n;
    do @(posedge clk); while (!s_axis_tready);
    board.note_cand(n);
  endtask

  // random candidate of a given bit width, top bit set
  function automatic logic [127:0] rand_cand(int w);
    logic [127:0] n;
    n = {$urandom, $urandom, $urandom, $urandom};
    if (w < 128) n = n & ((128'd1 << w) - 128'd1);
    n[w-1] = 1'b1;
    return n;
  endfunction

  // result side with random stalls
  initial begin
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = recv_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      board.check_word(m_axis_tdata);
      @(negedge clk);
    end
  end

  // stimulus and end of run
  initial begin
    logic [127:0] n;
    int w, pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: zero, one, two, three, small primes and pseudoprimes, extremes
    send_cand(128'd0);
    send_cand(128'd1);
    send_cand(128'd2);
    send_cand(128'd3);
    send_cand(128'd4);
    send_cand(128'd5);
    send_cand(128'd7);
    send_cand(128'd9);
    send_cand(128'd341);
    send_cand(128'd561);
    send_cand(128'd1000);
    send_cand({64'd0, 64'h1fffffffffffffff});
    send_cand({64'd0, {64{1'b1}}});
    send_cand({64'd1, 64'd0});
    send_cand({1'b0, {127{1'b1}}});
    send_cand({1'b1, 126'd0, 1'b1});
    send_cand({128{1'b1}});
    send_cand({{64{1'b1}}, 64'd0});

    // random: mostly narrow candidates, a few full-width ones
    for (int k = 0; k < 580; k++) begin
      if (k % 40 == 0) begin
        send_burst = ($urandom_range(0, 3) == 0);
        recv_burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 199);
      if (pick < 2) w = 128;
      else if (pick < 4) w = $urandom_range(25, 127);
      else if (pick < 50) w = $urandom_range(9, 20);
      else w = $urandom_range(1, 8);
      n = rand_cand(w);
      if ($urandom_range(0, 9) < 7) n[0] = 1'b1;
      send_cand(n);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // run time limit
  initial begin
    #320_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
